// File: rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants and types for the stable presence detector.
// ----------------------------------------------------------------------------
package spd_pkg;

    // window length default and field widths
    localparam int WINDOW_LEN_DEF = 3;
    localparam int RANGE_W        = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    // stream data widths, padded to whole bytes
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    // register reset values
    localparam logic [RANGE_W-1:0] THRESHOLD_RST = 16'd600;
    localparam logic [RANGE_W-1:0] TOLERANCE_RST = 16'd50;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE    = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_TOLERANCE = 2'd2
    } t_cfg_reg;

    // result flags, highest bit first
    typedef struct packed {
        logic object_present;
        logic object_left;
        logic object_arrived;
    } t_result;

endpackage

// File: rtl/stable_presence_detector.sv
// ----------------------------------------------------------------------------
// stable_presence_detector
// Reports when an object settles in front of a range sensor and when it
// leaves, from a short window of recent distance samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on the s_axis channel carry one sensor tick each: a sample
//   ready flag, a 16-bit distance in millimetres and a restart flag. Every
//   input beat yields exactly one result beat on m_axis with the arrival,
//   departure and present flags.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no beat is in flight: index 0 enable, 1 range threshold, 2 tolerance.
//   Throughput: one beat per cycle while no result waits untaken. Each
//   beat is registered through window update, mean multiply and deviation
//   compare. The mean is formed by a reciprocal multiply of a running sum.
//   When the result register holds an untaken beat, the whole pipeline
//   holds and s_axis_tready drops; it rises again once the beat is taken.
//   Reset clears the window to invalid entries, the present flag, the
//   pipeline, and loads enable 0, threshold 600 and tolerance 50. No beat
//   is lost or repeated across stalls.
// ----------------------------------------------------------------------------
module stable_presence_detector #(
    parameter int WINDOW_LEN = spd_pkg::WINDOW_LEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input tick: sample_ready[0], range_mm[16:1], restart[17], zero pad
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [spd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // result: object_arrived[0], object_left[1], object_present[2], zero pad
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [spd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [spd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [spd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import spd_pkg::*;

    // sum width and reciprocal for exact division by the window length
    localparam int SUM_W  = RANGE_W + $clog2(WINDOW_LEN);
    localparam int K      = SUM_W + $clog2(WINDOW_LEN);
    localparam int RCP_W  = K + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'((64'd1 << K) / WINDOW_LEN + 64'd1);

    // configuration registers
    logic                r_cfg_enable;
    logic [RANGE_W-1:0]  r_cfg_thr;
    logic [RANGE_W-1:0]  r_cfg_tol;

    // pipeline control
    logic                advance;
    logic                in_beat;

    // stage a: window state and running sum
    logic [RANGE_W-1:0]  r_win [WINDOW_LEN];
    logic [SUM_W-1:0]    r_sum;
    logic                r_a_vld;
    logic                r_a_restart;

    // stage b: mean and entry checks
    logic [RANGE_W-1:0]  r_b_win [WINDOW_LEN];
    logic [RANGE_W-1:0]  r_b_mean;
    logic                r_b_ok;
    logic                r_b_empty;
    logic                r_b_vld;
    logic                r_b_restart;

    // stage c: flag and result register
    logic                r_flag;
    logic                r_out_vld;
    t_result             r_out;

    // combinational values
    logic                in_ready_flag;
    logic [RANGE_W-1:0]  in_range;
    logic                in_restart;
    logic [RANGE_W-1:0]  n_new;
    logic                do_shift;
    logic [PROD_W-1:0]   prod;
    logic                n_ok;
    logic                n_empty;
    logic                dev_ok;
    logic [RANGE_W:0]    diff [WINDOW_LEN];
    logic                n_flag;
    t_result             n_out;

    // input field unpacking
    assign in_ready_flag = s_axis_tdata[0];
    assign in_range      = s_axis_tdata[RANGE_W:1];
    assign in_restart    = s_axis_tdata[RANGE_W+1];

    // the whole pipeline moves unless a result waits untaken
    assign advance       = !r_out_vld || m_axis_tready;
    assign s_axis_tready = advance;
    assign in_beat       = s_axis_tvalid && advance;

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_enable <= 1'b0;
            r_cfg_thr    <= THRESHOLD_RST;
            r_cfg_tol    <= TOLERANCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ENABLE:    r_cfg_enable <= i_cfg_data[0];
                REG_THRESHOLD: r_cfg_thr    <= i_cfg_data[RANGE_W-1:0];
                REG_TOLERANCE: r_cfg_tol    <= i_cfg_data[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // sample qualification: out-of-range samples enter as invalid
    always_comb begin
        if (in_range != '0 && in_range < r_cfg_thr) begin
            n_new = in_range;
        end else begin
            n_new = '0;
        end
    end

    assign do_shift = in_beat && r_cfg_enable && in_ready_flag;

    // stage a: shift window and keep running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_sum       <= '0;
            r_a_vld     <= 1'b0;
            r_a_restart <= 1'b0;
        end else if (advance) begin
            r_a_vld     <= s_axis_tvalid;
            r_a_restart <= in_restart;
            if (do_shift) begin
                for (int i = WINDOW_LEN - 1; i >= 1; i--) begin
                    r_win[i] <= r_win[i-1];
                end
                r_win[0] <= n_new;
                r_sum    <= r_sum + SUM_W'(n_new) - SUM_W'(r_win[WINDOW_LEN-1]);
            end
        end
    end

    // stage b logic: mean by reciprocal multiply, validity and empty checks
    assign prod = PROD_W'(r_sum) * PROD_W'(RECIP);

    always_comb begin
        n_ok    = 1'b1;
        n_empty = 1'b1;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            if (r_win[i] == '0 || r_win[i] > r_cfg_thr) begin
                n_ok = 1'b0;
            end
            if (r_win[i] != '0) begin
                n_empty = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld     <= 1'b0;
            r_b_restart <= 1'b0;
        end else if (advance) begin
            r_b_vld     <= r_a_vld;
            r_b_restart <= r_a_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_b_win[i] <= r_win[i];
            end
            r_b_mean  <= prod[K +: RANGE_W];
            r_b_ok    <= n_ok;
            r_b_empty <= n_empty;
        end
    end

    // stage c logic: deviation of each entry from the mean
    always_comb begin
        dev_ok = 1'b1;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            if (r_b_win[i] >= r_b_mean) begin
                diff[i] = {1'b0, r_b_win[i]} - {1'b0, r_b_mean};
            end else begin
                diff[i] = {1'b0, r_b_mean} - {1'b0, r_b_win[i]};
            end
            if (diff[i] > {1'b0, r_cfg_tol}) begin
                dev_ok = 1'b0;
            end
        end
    end

    // detection flag update: restart first, then one check per tick
    always_comb begin
        n_flag                = r_b_restart ? 1'b0 : r_flag;
        n_out.object_arrived  = 1'b0;
        n_out.object_left     = 1'b0;
        if (r_cfg_enable) begin
            if (!n_flag) begin
                if (r_b_ok && dev_ok) begin
                    n_flag               = 1'b1;
                    n_out.object_arrived = 1'b1;
                end
            end else if (r_b_empty) begin
                n_flag            = 1'b0;
                n_out.object_left = 1'b1;
            end
        end
        n_out.object_present = n_flag;
    end

    // result register and flag state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_b_vld;
            if (r_b_vld) begin
                r_flag <= n_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_b_vld) begin
            r_out <= n_out;
        end
    end

    // checks
    a_arrive_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.object_arrived) |-> (r_out.object_present && r_flag))
        else $error("arrival reported without present flag");

    a_left_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.object_left) |-> (!r_out.object_present && !r_flag))
        else $error("departure reported with present flag");

    a_stall_holds_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |=> $stable(r_sum))
        else $error("window changed while result stalled");

    a_disabled_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_cfg_enable) |-> (!r_out.object_arrived && !r_out.object_left))
        else $error("event reported while disabled");

endmodule

// File: bench/stable_presence_detector_tb.sv
// ----------------------------------------------------------------------------
// stable_presence_detector_tb
// Self-checking bench for the presence detector: ticks are streamed in with
// random gaps and receiver stalls, a behavioral copy of the detector
// predicts the arrival, departure and present flags of every tick, and each
// result beat is compared against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stable_presence_detector_tb;
    import spd_pkg::*;

    localparam int WIN = WINDOW_LEN_DEF;
    // index past the end of the register list, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 6;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // flags still owed by the block, oldest first
    t_result flags_due[$];
    int      fail_cnt = 0;
    bit      tx_gapless = 1'b0;
    bit      rx_hold_req = 1'b0;
    bit      rx_in_hold = 1'b0;

    // detector copy: configuration, window and present flag
    logic             en_model;
    logic [15:0]      thr_model;
    logic [15:0]      tol_model;
    logic [15:0]      win_model[WIN];
    logic             present_model;

    stable_presence_detector #(
        .WINDOW_LEN(WIN)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // watchdog
    initial begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // flags of one tick, advances the detector copy
    function automatic t_result next_presence_flags(logic rdy, logic [15:0] rng,
                                                     logic clr);
        t_result     r;
        int unsigned sum;
        int unsigned mean;
        int unsigned dev;
        bit          stable;
        bit          empty;
        r = '0;
        if (clr) present_model = 1'b0;
        if (en_model) begin
            if (rdy) begin
                for (int i = WIN - 1; i >= 1; i--) win_model[i] = win_model[i-1];
                win_model[0] = (rng != 0 && rng < thr_model) ? rng : 16'd0;
            end
            if (!present_model) begin
                // every entry valid and within tolerance of the truncated mean
                stable = 1'b1;
                sum = 0;
                for (int i = 0; i < WIN; i++) begin
                    if (win_model[i] == 0 || win_model[i] > thr_model) stable = 1'b0;
                    sum += win_model[i];
                end
                mean = sum / WIN;
                for (int i = 0; i < WIN; i++) begin
                    dev = (win_model[i] >= mean) ? win_model[i] - mean
                                                 : mean - win_model[i];
                    if (dev > tol_model) stable = 1'b0;
                end
                if (stable) begin
                    present_model = 1'b1;
                    r.object_arrived = 1'b1;
                end
            end else begin
                empty = 1'b1;
                for (int i = 0; i < WIN; i++)
                    if (win_model[i] != 0) empty = 1'b0;
                if (empty) begin
                    present_model = 1'b0;
                    r.object_left = 1'b1;
                end
            end
        end
        r.object_present = present_model;
        return r;
    endfunction

    // one input beat: optional gap, offer, wait for the handshake
    task automatic send_tick(logic rdy, logic [15:0] rng, logic clr);
        int gap;
        gap = tx_gapless ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, clr, rng, rdy};
        do @(posedge i_clk); while (!s_axis_tready);
        flags_due.push_back(next_presence_flags(rdy, rng, clr));
    endtask

    // stop offering and wait until every owed result has come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (flags_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, only called while the block is idle
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_ENABLE:    en_model = data[0];
            REG_THRESHOLD: thr_model = data;
            REG_TOLERANCE: tol_model = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver ready: random stretches, plus one long hold on request
    initial begin : rx_ready_gen
        int run;
        int gap;
        forever begin
            if (rx_hold_req) begin
                rx_in_hold = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
                rx_in_hold = 1'b0;
            end
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                              : $urandom_range(1, 6);
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[2:0]);
            if (flags_due.size() == 0) begin
                $error("result beat with nothing outstanding: %03b", got);
                fail_cnt++;
            end else begin
                want = flags_due.pop_front();
                if (got.object_arrived !== want.object_arrived) begin
                    $error("object_arrived: expected %0b, got %0b",
                           want.object_arrived, got.object_arrived);
                    fail_cnt++;
                end
                if (got.object_left !== want.object_left) begin
                    $error("object_left: expected %0b, got %0b",
                           want.object_left, got.object_left);
                    fail_cnt++;
                end
                if (got.object_present !== want.object_present) begin
                    $error("object_present: expected %0b, got %0b",
                           want.object_present, got.object_present);
                    fail_cnt++;
                end
            end
        end
    end

    // reset values: disabled, so nothing is stored and no event fires
    task automatic test_disabled_after_reset();
        send_tick(1'b1, 16'd300, 1'b0);
        send_tick(1'b1, 16'd300, 1'b0);
        send_tick(1'b1, 16'd300, 1'b1);
        send_tick(1'b1, 16'd300, 1'b0);
        drain_results();
    endtask

    // basic arrival, restart while present, departure, range edges
    task automatic test_arrival_and_departure();
        cfg_write(REG_ENABLE, 16'd1);
        cfg_write(REG_THRESHOLD, 16'd600);
        cfg_write(REG_TOLERANCE, 16'd50);
        send_tick(1'b1, 16'd300, 1'b0);
        send_tick(1'b1, 16'd350, 1'b0);
        send_tick(1'b1, 16'd250, 1'b0);
        // restart clears the flag, window still stable so it arrives again
        send_tick(1'b1, 16'd300, 1'b1);
        // tick without a sample leaves the window alone
        send_tick(1'b0, 16'd65535, 1'b0);
        // zero, at threshold and top of range are all invalid
        send_tick(1'b1, 16'd0, 1'b0);
        send_tick(1'b1, 16'd600, 1'b0);
        send_tick(1'b1, 16'd65535, 1'b0);
        send_tick(1'b1, 16'd599, 1'b0);
        send_tick(1'b1, 16'd599, 1'b0);
        send_tick(1'b1, 16'd599, 1'b0);
        send_tick(1'b1, 16'd1, 1'b0);
        send_tick(1'b1, 16'd1, 1'b0);
        send_tick(1'b1, 16'd0, 1'b0);
        send_tick(1'b1, 16'd0, 1'b0);
        send_tick(1'b1, 16'd0, 1'b0);
        // lowest valid sample everywhere
        send_tick(1'b1, 16'd1, 1'b0);
        send_tick(1'b1, 16'd1, 1'b0);
        send_tick(1'b1, 16'd1, 1'b0);
        drain_results();
    endtask

    // threshold lowered under stored samples, tolerance at both ends
    task automatic test_lowered_threshold();
        cfg_write(REG_THRESHOLD, 16'd1000);
        cfg_write(REG_TOLERANCE, 16'd0);
        send_tick(1'b1, 16'd0, 1'b0);
        send_tick(1'b1, 16'd0, 1'b0);
        send_tick(1'b1, 16'd0, 1'b0);
        send_tick(1'b1, 16'd500, 1'b0);
        send_tick(1'b1, 16'd500, 1'b0);
        send_tick(1'b1, 16'd501, 1'b0);
        send_tick(1'b1, 16'd500, 1'b0);
        send_tick(1'b1, 16'd500, 1'b0);
        drain_results();
        cfg_write(REG_THRESHOLD, 16'd400);
        // entries now above threshold, re-arrival after restart must fail
        send_tick(1'b0, 16'd0, 1'b1);
        drain_results();
        cfg_write(REG_THRESHOLD, 16'd65535);
        cfg_write(REG_TOLERANCE, 16'd65535);
        send_tick(1'b1, 16'd65534, 1'b0);
        send_tick(1'b1, 16'd1, 1'b1);
        send_tick(1'b1, 16'd65534, 1'b1);
        drain_results();
    endtask

    // threshold zero stores only invalid entries, spare index, disable
    task automatic test_threshold_zero();
        cfg_write(REG_THRESHOLD, 16'd0);
        send_tick(1'b1, 16'd100, 1'b0);
        send_tick(1'b1, 16'd100, 1'b0);
        send_tick(1'b1, 16'd100, 1'b0);
        drain_results();
        cfg_write(REG_SPARE, 16'hffff);
        cfg_write(REG_THRESHOLD, 16'd600);
        cfg_write(REG_TOLERANCE, 16'd50);
        send_tick(1'b1, 16'd200, 1'b0);
        send_tick(1'b1, 16'd210, 1'b0);
        send_tick(1'b1, 16'd190, 1'b0);
        drain_results();
        // disabled while present: restart still clears the flag
        cfg_write(REG_ENABLE, 16'd0);
        send_tick(1'b1, 16'd0, 1'b0);
        send_tick(1'b1, 16'd0, 1'b1);
        drain_results();
        cfg_write(REG_ENABLE, 16'd1);
    endtask

    // receiver holds off long while ticks keep coming back to back
    task automatic test_backpressure();
        rx_hold_req = 1'b1;
        tx_gapless = 1'b1;
        // start offering only once the receiver has begun its hold
        while (!rx_in_hold) @(posedge i_clk);
        for (int i = 0; i < 40; i++) begin
            if (i % 10 < 6)
                send_tick(1'b1, 16'(300 + $urandom_range(0, 40)), 1'b0);
            else
                send_tick(1'b1, 16'd0, 1'b0);
        end
        tx_gapless = 1'b0;
        drain_results();
    endtask

    // random phases: new settings, then mostly presence and absence bursts
    task automatic test_random_phases();
        int unsigned thr;
        int unsigned tol;
        int unsigned base;
        int unsigned span;
        int unsigned len;
        int unsigned kind;
        int          sent;
        int          s;
        int          ph;
        for (ph = 0; ph < 9; ph++) begin
            case ($urandom_range(0, 4))
                0: thr = 1;
                1: thr = 65535;
                2: thr = 600;
                3: thr = $urandom_range(1, 65535);
                default: thr = $urandom_range(50, 2000);
            endcase
            case ($urandom_range(0, 3))
                0: tol = 0;
                1: tol = 65535;
                2: tol = $urandom_range(0, 100);
                default: tol = $urandom_range(0, 65535);
            endcase
            cfg_write(REG_ENABLE, (ph == 4) ? 16'd0 : 16'd1);
            cfg_write(REG_THRESHOLD, 16'(thr));
            cfg_write(REG_TOLERANCE, 16'(tol));
            tx_gapless = (ph % 3 == 1);
            sent = 0;
            while (sent < 95) begin
                kind = $urandom_range(0, 99);
                if (kind < 60) begin
                    // object held still, spread around the tolerance
                    base = (thr > 1) ? $urandom_range(1, thr - 1) : 1;
                    span = ($urandom_range(0, 3) == 0) ? tol : tol / 2;
                    if (span > 1000) span = 1000;
                    len = $urandom_range(3, 8);
                    repeat (len) begin
                        s = int'(base) + int'($urandom_range(0, 2 * span)) - int'(span);
                        if (s < 1) s = 1;
                        if (s > 65535) s = 65535;
                        send_tick($urandom_range(0, 9) != 0, 16'(s),
                                  $urandom_range(0, 29) == 0);
                        sent++;
                    end
                end else if (kind < 85) begin
                    // object gone: invalid samples of every kind
                    len = $urandom_range(3, 6);
                    repeat (len) begin
                        case ($urandom_range(0, 2))
                            0: s = 0;
                            1: s = 65535;
                            default: s = $urandom_range(thr, 65535);
                        endcase
                        send_tick(1'b1, 16'(s), $urandom_range(0, 29) == 0);
                        sent++;
                    end
                end else begin
                    // noise
                    send_tick(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                              $urandom_range(0, 7) == 0);
                    sent++;
                end
            end
            tx_gapless = 1'b0;
            drain_results();
        end
    endtask

    // test sequence
    initial begin
        en_model = 1'b0;
        thr_model = THRESHOLD_RST;
        tol_model = TOLERANCE_RST;
        present_model = 1'b0;
        for (int i = 0; i < WIN; i++) win_model[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled_after_reset();
        test_arrival_and_departure();
        test_lowered_threshold();
        test_threshold_zero();
        test_backpressure();
        test_random_phases();
        drain_results();
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
